[rtl/oed_pkg.sv]
// ----------------------------------------------------------------------------
// oed_pkg
// Shared sizes, register codes, types and helpers of the obstacle edge detector.
// ----------------------------------------------------------------------------
package oed_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // column index, clamped width, clamped height, row position (two rows past the image)
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

  localparam int SIZE_W  = 11;
  localparam int LIMIT_W = 8;
  localparam int CHAN_W  = 8;
  localparam int EDGE_W  = 10;
  localparam int FLAG_W  = 3;
  localparam int WIN_W   = 9;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 4;

  localparam logic [SIZE_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [SIZE_W-1:0]  FRAME_HEIGHT_RST = 11'd480;
  localparam logic [LIMIT_W-1:0] DARK_LIMIT_RST   = 8'd10;
  localparam logic [LIMIT_W-1:0] WHITE_LIMIT_RST  = 8'd200;

  // bits of one line buffer entry
  localparam int FLAG_W1 = 0;
  localparam int FLAG_W2 = 1;
  localparam int FLAG_D1 = 2;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_DARK_LIMIT   = 2'd2,
    REG_WHITE_LIMIT  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [WID_W-1:0]   width;
    logic [HGT_W-1:0]   height;
    logic [LIMIT_W-1:0] dark;
    logic [LIMIT_W-1:0] white;
  } cfg_t;

  typedef struct packed {
    logic             white;
    logic             dark;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } item_t;

  typedef struct packed {
    logic              en;
    logic [COL_W-1:0]  addr;
    logic [FLAG_W-1:0] data;
  } ram_wr_t;

  function automatic logic [WID_W-1:0] clamp_width(input logic [SIZE_W-1:0] v);
    logic [WID_W-1:0] r;
    if (v == '0) begin
      r = WID_W'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      r = WID_W'(MAX_WIDTH);
    end else begin
      r = WID_W'(v);
    end
    return r;
  endfunction

  function automatic logic [HGT_W-1:0] clamp_height(input logic [SIZE_W-1:0] v);
    logic [HGT_W-1:0] r;
    if (v == '0) begin
      r = HGT_W'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      r = HGT_W'(MAX_HEIGHT);
    end else begin
      r = HGT_W'(v);
    end
    return r;
  endfunction

endpackage

[rtl/oed_ram.sv]
// ----------------------------------------------------------------------------
// oed_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module oed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read before write on a shared address
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/oed_front.sv]
// ----------------------------------------------------------------------------
// oed_front
// Input side: stream position, pixel classification, line buffer read and the
// clearing sweep that runs after reset.
// ----------------------------------------------------------------------------
module oed_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  oed_pkg::cfg_t                     cfg,
  input  logic                              restart,
  input  logic                              stage_free,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic                              in_tuser,
  input  logic [oed_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              acc,
  output oed_pkg::item_t                    item,
  output logic                              rd_en,
  output logic [oed_pkg::COL_W-1:0]         rd_addr,
  output oed_pkg::ram_wr_t                  clr_wr
);

  logic [oed_pkg::COL_W-1:0] col_r, col_nxt;
  logic [oed_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                      clearing_r, clearing_nxt;
  logic [oed_pkg::COL_W-1:0] clr_addr_r, clr_addr_nxt;

  logic [oed_pkg::CHAN_W-1:0] blue, green, red;
  logic                       in_image;
  logic [oed_pkg::WID_W-1:0]  col_inc;

  assign blue  = in_tdata[oed_pkg::CHAN_W-1:0];
  assign green = in_tdata[2*oed_pkg::CHAN_W-1:oed_pkg::CHAN_W];
  assign red   = in_tdata[3*oed_pkg::CHAN_W-1:2*oed_pkg::CHAN_W];

  assign in_tready = !clearing_r && stage_free;
  assign acc       = in_tvalid && in_tready;

  // flush items and anything past the last image row count as outside
  assign in_image = !in_tuser &&
                    ((oed_pkg::ROW_W+1)'(row_r) < (oed_pkg::ROW_W+1)'(cfg.height));

  always_comb begin
    item.white = in_image && (blue > cfg.white) && (green > cfg.white) && (red > cfg.white);
    item.dark  = in_image && (blue < cfg.dark) && (green < cfg.dark) && (red < cfg.dark);
    item.col   = col_r;
    item.row   = row_r;
  end

  assign rd_en   = acc;
  assign rd_addr = col_r;

  assign clr_wr.en   = clearing_r;
  assign clr_wr.addr = clr_addr_r;
  assign clr_wr.data = '0;

  assign col_inc = oed_pkg::WID_W'(col_r) + 1'b1;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (acc) begin
      if ((oed_pkg::ROW_W+1)'(row_r) >= (oed_pkg::ROW_W+1)'(cfg.height) + 1'b1) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= cfg.width) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_inc[oed_pkg::COL_W-1:0];
      end
    end
  end

  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == oed_pkg::COL_W'(oed_pkg::MAX_WIDTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

endmodule

[rtl/oed_back.sv]
// ----------------------------------------------------------------------------
// oed_back
// Line buffer update with forwarding, 3x3 white window, boundary test and the
// output register.
// ----------------------------------------------------------------------------
module oed_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  oed_pkg::cfg_t                      cfg,
  input  logic                               acc,
  input  oed_pkg::item_t                     item,
  input  logic [oed_pkg::FLAG_W-1:0]         rd_data,
  output logic                               stage_free,
  output oed_pkg::ram_wr_t                   wr,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [oed_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic                        b_valid_r, b_valid_nxt;
  oed_pkg::item_t              b_item_r;
  logic                        fwd_r;
  logic [oed_pkg::FLAG_W-1:0]  fwd_data_r;
  logic [oed_pkg::WIN_W-1:0]   win_r, win_nxt;
  logic [1:0]                  cdark_r, cdark_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [oed_pkg::EDGE_W-1:0]  out_col_r, out_row_r;

  logic                        b_fire;
  logic [oed_pkg::FLAG_W-1:0]  flags, new_flags;
  logic                        c_nz, cr_ok, pos_ok, hit;
  logic [oed_pkg::COL_W-1:0]   cc;
  logic [oed_pkg::ROW_W-1:0]   cr;
  logic [2:0]                  col_ok, row_ok;
  logic [oed_pkg::WIN_W-1:0]   mask;

  assign b_fire     = b_valid_r && (!out_valid_r || out_tready);
  assign stage_free = !b_valid_r || b_fire;

  // entry written in the same cycle as this item's read comes from the bypass
  assign flags     = fwd_r ? fwd_data_r : rd_data;
  assign new_flags = {b_item_r.dark, flags[oed_pkg::FLAG_W1], b_item_r.white};

  assign wr.en   = b_fire;
  assign wr.addr = b_item_r.col;
  assign wr.data = new_flags;

  assign win_nxt   = {b_item_r.white, flags[oed_pkg::FLAG_W1], flags[oed_pkg::FLAG_W2],
                      win_r[oed_pkg::WIN_W-1:3]};
  assign cdark_nxt = {flags[oed_pkg::FLAG_D1], cdark_r[1]};

  // window center sits one row and one column back, or at the end of the row before last
  always_comb begin
    c_nz = b_item_r.col != '0;
    if (c_nz) begin
      cc    = b_item_r.col - 1'b1;
      cr    = b_item_r.row - 1'b1;
      cr_ok = b_item_r.row != '0;
    end else begin
      cc    = oed_pkg::COL_W'(cfg.width - 1'b1);
      cr    = b_item_r.row - oed_pkg::ROW_W'(2);
      cr_ok = b_item_r.row >= oed_pkg::ROW_W'(2);
    end
    pos_ok = cr_ok && ((oed_pkg::ROW_W+1)'(cr) < (oed_pkg::ROW_W+1)'(cfg.height));
    col_ok = {((oed_pkg::WID_W+1)'(cc) + 1'b1) < (oed_pkg::WID_W+1)'(cfg.width),
              1'b1, cc != '0};
    row_ok = {((oed_pkg::ROW_W+1)'(cr) + 1'b1) < (oed_pkg::ROW_W+1)'(cfg.height),
              1'b1, cr != '0};
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        mask[k*3+j] = col_ok[k] && row_ok[j];
      end
    end
    hit = pos_ok && cdark_nxt[0] && (|(win_nxt & mask));
  end

  assign b_valid_nxt   = acc ? 1'b1 : (b_fire ? 1'b0 : b_valid_r);
  assign out_valid_nxt = b_fire ? hit : (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      fwd_r       <= 1'b0;
      win_r       <= '0;
      cdark_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        fwd_r <= b_fire && (b_item_r.col == item.col);
      end
      if (b_fire) begin
        win_r   <= win_nxt;
        cdark_r <= cdark_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_item_r   <= item;
      fwd_data_r <= new_flags;
    end
    if (b_fire && hit) begin
      out_col_r <= oed_pkg::EDGE_W'(cc);
      out_row_r <= oed_pkg::EDGE_W'(cr);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(oed_pkg::OUT_TDATA_W - 2*oed_pkg::EDGE_W)'(0), out_row_r, out_col_r};

endmodule

[rtl/obstacle_edge_detect.sv]
// ----------------------------------------------------------------------------
// obstacle_edge_detect
// Streaming 3x3 boundary detector for dark obstacle pixels next to white ones.
// ----------------------------------------------------------------------------
// Takes one RGB pixel per clock in raster order and reports, in raster order,
// every obstacle pixel with a white pixel in its in-image 3x3 neighbourhood as
// a column/row pair. Results lag the input by frame_width+1 items, so a frame
// is followed by frame_width+1 flush items (tuser high). An accepted pixel
// waits in the stage register while the result side stalls; otherwise
// throughput is one item per clock, set by the line buffer RAM, read when a
// pixel is taken and written back as it leaves the stage register, with a
// bypass on a shared column. After reset all its 1024 entries are cleared
// (one entry a cycle) with in_tready low; configuration writes are taken
// meanwhile. Writing frame_width or frame_height restarts the frame position.
module obstacle_edge_detect (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [oed_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [oed_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [oed_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready,
  // pixel stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [oed_pkg::IN_TDATA_W-1:0]     in_tdata,   // blue, green, red
  input  logic                               in_tuser,   // kind
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [oed_pkg::OUT_TDATA_W-1:0]    out_tdata   // edge_col, edge_row, zero pad
);

  logic [oed_pkg::SIZE_W-1:0]  frame_width_r, frame_height_r;
  logic [oed_pkg::LIMIT_W-1:0] dark_limit_r, white_limit_r;

  oed_pkg::reg_idx_t           cfg_idx;
  logic                        cfg_wr;
  logic                        restart;
  oed_pkg::cfg_t               cfg;

  logic                        stage_free, acc, rd_en;
  oed_pkg::item_t              item;
  logic [oed_pkg::COL_W-1:0]   rd_addr;
  logic [oed_pkg::FLAG_W-1:0]  rd_data;
  oed_pkg::ram_wr_t            clr_wr, upd_wr, ram_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = oed_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign restart    = cfg_wr && ((cfg_idx == oed_pkg::REG_FRAME_WIDTH) ||
                                 (cfg_idx == oed_pkg::REG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= oed_pkg::FRAME_WIDTH_RST;
      frame_height_r <= oed_pkg::FRAME_HEIGHT_RST;
      dark_limit_r   <= oed_pkg::DARK_LIMIT_RST;
      white_limit_r  <= oed_pkg::WHITE_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        oed_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[oed_pkg::SIZE_W-1:0];
        oed_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[oed_pkg::SIZE_W-1:0];
        oed_pkg::REG_DARK_LIMIT:   dark_limit_r   <= cfg_pwdata[oed_pkg::LIMIT_W-1:0];
        oed_pkg::REG_WHITE_LIMIT:  white_limit_r  <= cfg_pwdata[oed_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      oed_pkg::REG_FRAME_WIDTH:  cfg_prdata = oed_pkg::CFG_DATA_W'(frame_width_r);
      oed_pkg::REG_FRAME_HEIGHT: cfg_prdata = oed_pkg::CFG_DATA_W'(frame_height_r);
      oed_pkg::REG_DARK_LIMIT:   cfg_prdata = oed_pkg::CFG_DATA_W'(dark_limit_r);
      oed_pkg::REG_WHITE_LIMIT:  cfg_prdata = oed_pkg::CFG_DATA_W'(white_limit_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg.width  = oed_pkg::clamp_width(frame_width_r);
    cfg.height = oed_pkg::clamp_height(frame_height_r);
    cfg.dark   = dark_limit_r;
    cfg.white  = white_limit_r;
  end

  oed_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .restart    (restart),
    .stage_free (stage_free),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .acc        (acc),
    .item       (item),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .clr_wr     (clr_wr)
  );

  // clearing sweep owns the write port until done, no items flow meanwhile
  assign ram_wr = clr_wr.en ? clr_wr : upd_wr;

  oed_ram #(
    .WIDTH (oed_pkg::FLAG_W),
    .DEPTH (oed_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  oed_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .acc        (acc),
    .item       (item),
    .rd_data    (rd_data),
    .stage_free (stage_free),
    .wr         (upd_wr),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[rtl/oed_checker.sv]
// ----------------------------------------------------------------------------
// oed_checker
// Port-level checks of the obstacle edge detector, bound to the top level.
// ----------------------------------------------------------------------------
module oed_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [oed_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // line buffer clearing blocks input right after reset
  assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready during line buffer clearing");

endmodule

bind obstacle_edge_detect oed_checker u_oed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[sim/edge_tracker_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_tracker_pkg
// Expected-edge prediction and result checking for the obstacle edge bench.
// ----------------------------------------------------------------------------
// Keeps its own copy of the detector registers, line flags and 3x3 window,
// steps them for every accepted pixel request and queues the obstacle
// boundary positions the block has to report, in raster order.
package edge_tracker_pkg;
  import oed_pkg::*;

  typedef struct {
    logic [EDGE_W-1:0] col;
    logic [EDGE_W-1:0] row;
  } edge_pos_t;

  class edge_tracker;
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [LIMIT_W-1:0] dark_lim;
    logic [LIMIT_W-1:0] white_lim;
    logic [FLAG_W-1:0]  line_flags [MAX_WIDTH];
    logic [WIN_W-1:0]   win_white;
    logic [1:0]         mid_dark;
    int                 col_pos;
    int                 row_pos;
    edge_pos_t          expected_edges [$];
    int unsigned        failures;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      dark_lim   = DARK_LIMIT_RST;
      white_lim  = WHITE_LIMIT_RST;
      foreach (line_flags[i]) line_flags[i] = '0;
      win_white = '0;
      mid_dark  = '0;
      col_pos   = 0;
      row_pos   = 0;
      failures  = 0;
    endfunction

    function int clamp_size(logic [SIZE_W-1:0] v, int hi);
      if (v == '0) return 1;
      if (int'(v) > hi) return hi;
      return int'(v);
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_FRAME_WIDTH: begin
          width_reg = value[SIZE_W-1:0];
          col_pos   = 0;
          row_pos   = 0;
        end
        REG_FRAME_HEIGHT: begin
          height_reg = value[SIZE_W-1:0];
          col_pos    = 0;
          row_pos    = 0;
        end
        REG_DARK_LIMIT:  dark_lim  = value[LIMIT_W-1:0];
        REG_WHITE_LIMIT: white_lim = value[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_edge(logic kind, logic [IN_TDATA_W-1:0] data);
      logic [CHAN_W-1:0] b, g, r;
      logic              in_image, is_white, is_dark;
      logic [FLAG_W-1:0] flags;
      logic [WIN_W-1:0]  mask;
      int                w, h, c, row, cc, cr, x, y, k, j;
      edge_pos_t         hit;
      w   = clamp_size(width_reg, MAX_WIDTH);
      h   = clamp_size(height_reg, MAX_HEIGHT);
      b   = data[7:0];
      g   = data[15:8];
      r   = data[23:16];
      c   = col_pos;
      row = row_pos;
      // flush requests and anything past the last row are outside the image
      in_image = !kind && (row < h);
      is_white = in_image && b > white_lim && g > white_lim && r > white_lim;
      is_dark  = in_image && b < dark_lim && g < dark_lim && r < dark_lim;
      flags = line_flags[c];
      line_flags[c] = {is_dark, flags[FLAG_W1], is_white};
      win_white = {is_white, flags[FLAG_W1], flags[FLAG_W2], win_white[WIN_W-1:3]};
      mid_dark  = {flags[FLAG_D1], mid_dark[1]};
      // window center trails the incoming position by one row and one column
      if (c >= 1) begin
        cc = c - 1;
        cr = row - 1;
      end else begin
        cc = w - 1;
        cr = row - 2;
      end
      if (cc >= 0 && cr >= 0 && cc < w && cr < h && mid_dark[0]) begin
        mask = '0;
        for (k = 0; k < 3; k++) begin
          x = cc + k - 1;
          if (x >= 0 && x < w) begin
            for (j = 0; j < 3; j++) begin
              y = cr + j - 1;
              if (y >= 0 && y < h) mask[k*3+j] = 1'b1;
            end
          end
        end
        if ((win_white & mask) != '0) begin
          hit.col = cc[EDGE_W-1:0];
          hit.row = cr[EDGE_W-1:0];
          expected_edges.insert(expected_edges.size(), hit);
        end
      end
      if (row >= h + 1) begin
        col_pos = 0;
        row_pos = 0;
      end else begin
        c++;
        if (c >= w) begin
          c = 0;
          row++;
        end
        col_pos = c;
        row_pos = row;
      end
    endfunction

    function void check_edge(logic [OUT_TDATA_W-1:0] data);
      edge_pos_t want;
      if (expected_edges.size() == 0) begin
        $error("unexpected edge: col %0d row %0d", data[9:0], data[19:10]);
        failures++;
        return;
      end
      want = expected_edges[0];
      expected_edges.delete(0);
      if (data[9:0] !== want.col) begin
        $error("edge_col mismatch: expected %0d, actual %0d", want.col, data[9:0]);
        failures++;
      end
      if (data[19:10] !== want.row) begin
        $error("edge_row mismatch: expected %0d, actual %0d", want.row, data[19:10]);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_edges.size();
    endfunction

    function void finish_check();
      if (expected_edges.size() != 0) begin
        $error("%0d expected edges never arrived", expected_edges.size());
        failures++;
      end
    endfunction
  endclass

endpackage

[sim/tb_obstacle_edge_detect.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_obstacle_edge_detect
// Self-checking bench for the streaming obstacle boundary detector.
// ----------------------------------------------------------------------------
// Writes frame sizes and color limits over the register port, streams small
// frames plus their flush tail with bursty requests and a stalling result
// side, and compares every reported edge position with the tracker's queue.
// Extreme and clamped sizes, overlapping limits and misplaced kinds are mixed
// in, and one long result stall backs the pixel input up.
module tb_obstacle_edge_detect;
  import oed_pkg::*;
  import edge_tracker_pkg::*;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef enum int {PIX_DARK, PIX_WHITE, PIX_NOISE, PIX_BORDER, PIX_ANY} pix_mode_t;
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_RARE, SINK_PATTERN} sink_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // blue, green, red
  logic                   in_tuser;   // kind
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // edge_col, edge_row, zero pad

  edge_tracker edges;
  bit          hold_request;
  bit          sender_gaps;
  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned frame_w;
  int unsigned frame_h;
  int unsigned dark_cur;
  int unsigned white_cur;

  obstacle_edge_detect dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      edges.write_reg(reg_idx_t'(cfg_paddr[3:2]), cfg_pwdata);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) edges.predict_edge(in_tuser, in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) edges.check_edge(out_tdata);
  end

  // result side: changing stall patterns, plus one long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned tick;
    sink_mode_t  mode;
    logic [15:0] stall_pattern;
    hold_left     = 0;
    mode_left     = 0;
    tick          = 0;
    mode          = SINK_OPEN;
    stall_pattern = '1;
    out_tready    = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode          = sink_mode_t'($urandom_range(0, 3));
          mode_left     = $urandom_range(20, 200);
          stall_pattern = 16'($urandom);
        end
        mode_left--;
        case (mode)
          SINK_OPEN: out_tready <= 1'b1;
          SINK_COIN: out_tready <= 1'($urandom_range(0, 1));
          SINK_RARE: out_tready <= ($urandom_range(0, 7) != 0);
          default:   out_tready <= stall_pattern[tick % 16];
        endcase
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic cfg_write(reg_idx_t idx, int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
  endtask

  // stop requesting, wait for every expected edge, then let the pipe empty
  task automatic drain();
    in_tvalid <= 1'b0;
    while (edges.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned dl,
                           int unsigned wl, bit write_size);
    drain();
    if (write_size) begin
      cfg_write(REG_FRAME_WIDTH, w);
      cfg_write(REG_FRAME_HEIGHT, h);
      frame_w = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
      frame_h = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
    end
    cfg_write(REG_DARK_LIMIT, dl);
    cfg_write(REG_WHITE_LIMIT, wl);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    dark_cur  = dl;
    white_cur = wl;
  endtask

  task automatic offer(logic kind, logic [IN_TDATA_W-1:0] pix);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = sender_gaps ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  function automatic logic [IN_TDATA_W-1:0] pick_pixel(pix_mode_t mode);
    logic [CHAN_W-1:0] ch [3];
    pix_mode_t         m;
    int unsigned       roll;
    int                i;
    m = mode;
    if (m == PIX_ANY) begin
      roll = $urandom_range(0, 99);
      m = (roll < 35) ? PIX_DARK : (roll < 70) ? PIX_WHITE : (roll < 90) ? PIX_NOISE : PIX_BORDER;
    end
    for (i = 0; i < 3; i++) begin
      case (m)
        PIX_DARK:  ch[i] = CHAN_W'((dark_cur != 0) ? $urandom_range(0, dark_cur - 1) : $urandom);
        PIX_WHITE: ch[i] = CHAN_W'((white_cur != 255) ? $urandom_range(white_cur + 1, 255) :
                                   $urandom);
        PIX_NOISE: ch[i] = CHAN_W'($urandom);
        // values right at or next to either limit
        default: begin
          roll = $urandom_range(0, 3);
          ch[i] = (roll == 0) ? CHAN_W'(dark_cur) : (roll == 1) ? CHAN_W'(dark_cur - 1) :
                  (roll == 2) ? CHAN_W'(white_cur) : CHAN_W'(white_cur + 1);
        end
      endcase
    end
    return {ch[2], ch[1], ch[0]};
  endfunction

  // frames and flush tail, optionally truncated; noise flips some request kinds
  task automatic send_frames(int unsigned frames, int unsigned noise_pct, bit grid,
                             bit truncate, int unsigned max_items);
    int unsigned per_frame, total, stop, n, x, y;
    logic        kind;
    per_frame = frame_w * frame_h + frame_w + 1;
    total     = frames * per_frame;
    stop      = truncate ? $urandom_range(1, total) : total;
    if (stop > max_items) stop = max_items;
    for (n = 0; n < stop; n++) begin
      x = (n % per_frame) % frame_w;
      y = (n % per_frame) / frame_w;
      kind = (y >= frame_h) ? KIND_FLUSH : KIND_PIXEL;
      if ($urandom_range(0, 99) < noise_pct) kind = !kind;
      if (grid) begin
        offer(kind, pick_pixel(((x + y) % 2 == 0) ? PIX_DARK : PIX_WHITE));
      end else begin
        offer(kind, pick_pixel(PIX_ANY));
      end
    end
  endtask

  initial begin
    int unsigned random_start, w, h, dl, wl;
    edges        = new();
    hold_request = 1'b0;
    sender_gaps  = 1'b1;
    burst_left   = 0;
    items_sent   = 0;
    frame_w      = 640;
    frame_h      = 480;
    dark_cur     = 10;
    white_cur    = 200;
    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = KIND_PIXEL;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // small hand-made frame: borders, exact limits, misplaced kinds
    configure(4, 3, 10, 200, 1'b1);
    offer(KIND_PIXEL, 24'hffffff);
    offer(KIND_PIXEL, 24'h000000);
    offer(KIND_PIXEL, 24'h090909);
    offer(KIND_PIXEL, 24'hc9c9c9);
    offer(KIND_PIXEL, 24'h000000);
    offer(KIND_PIXEL, 24'h0a0000);
    offer(KIND_PIXEL, 24'h00ff00);
    offer(KIND_PIXEL, 24'h090000);
    offer(KIND_FLUSH, 24'h000000);
    offer(KIND_PIXEL, 24'h000000);
    offer(KIND_PIXEL, 24'hffffc8);
    offer(KIND_PIXEL, 24'h000000);
    offer(KIND_FLUSH, 24'h123456);
    offer(KIND_PIXEL, 24'h000000);
    offer(KIND_FLUSH, 24'hffffff);
    offer(KIND_FLUSH, 24'h000000);
    offer(KIND_FLUSH, 24'habcdef);
    // limits overlap: mid gray is dark and white at once
    configure(2, 2, 255, 0, 1'b1);
    offer(KIND_PIXEL, 24'h646464);
    offer(KIND_PIXEL, 24'h000000);
    offer(KIND_PIXEL, 24'hffffff);
    offer(KIND_PIXEL, 24'h010101);
    offer(KIND_FLUSH, 24'h000000);
    offer(KIND_PIXEL, 24'h000000);
    offer(KIND_FLUSH, 24'hffffff);

    // size extremes: height clamped to the maximum, both sizes clamped up from zero
    configure(1, 2047, 255, 0, 1'b1);
    send_frames(1, 2, 1'b0, 1'b0, 2000);
    configure(0, 0, 0, 255, 1'b1);
    send_frames(3, 0, 1'b0, 1'b0, 100);

    // result side held off while dense edges keep coming
    configure(16, 8, 10, 200, 1'b1);
    sender_gaps  = 1'b0;
    hold_request = 1'b1;
    send_frames(1, 0, 1'b1, 1'b0, 200);

    random_start = items_sent;
    while (items_sent < random_start + 200) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      case ($urandom_range(0, 3))
        0: begin
          dl = 10;
          wl = 200;
        end
        1: begin
          dl = $urandom_range(1, 128);
          wl = $urandom_range(100, 254);
        end
        2: begin
          dl = $urandom_range(128, 255);
          wl = $urandom_range(0, 127);
        end
        default: begin
          dl = $urandom_range(0, 255);
          wl = $urandom_range(0, 255);
        end
      endcase
      configure(w, h, dl, wl, ($urandom_range(0, 4) != 0));
      sender_gaps = ($urandom_range(0, 3) != 0);
      send_frames($urandom_range(1, 3), ($urandom_range(0, 4) == 0) ? 5 : 0,
                  ($urandom_range(0, 5) == 0), ($urandom_range(0, 9) == 0),
                  random_start + 200 - items_sent);
    end

    drain();
    repeat (20) @(negedge clk);
    edges.finish_check();
    if (edges.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/oed_pkg.sv
rtl/oed_ram.sv
rtl/oed_front.sv
rtl/oed_back.sv
rtl/obstacle_edge_detect.sv
rtl/oed_checker.sv
sim/edge_tracker_pkg.sv
sim/tb_obstacle_edge_detect.sv
